// ===== rtl/ompf_pkg.sv =====
package ompf_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_BINS   = 256;

    localparam int DIM_W   = 7;
    localparam int RAD_W   = 4;
    localparam int BIN_W   = 8;
    localparam int POS_W   = 12;
    localparam int TOT_W   = 13;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int CNT_W   = 10;
    localparam int SUM_W   = 18;
    localparam int PADDR_W = 4;
    localparam int QDEPTH  = 2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_in;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       last_pixel;
    } t_out;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [RAD_W-1:0] radius;
        logic [BIN_W-1:0] top;
    } t_cfg;

    typedef struct packed {
        logic valid;
        t_in  item;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sb;
        logic [SUM_W-1:0] sg;
        logic [SUM_W-1:0] sr;
    } t_bin;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SYNC,
        S_CLEAR,
        S_PIX_RD,
        S_PIX_GRAY,
        S_PIX_BIN,
        S_PIX_ACC,
        S_FIND,
        S_DIV
    } t_state;

    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_RADIUS,
        REG_TOP
    } t_reg;

endpackage

// ===== rtl/ompf_front.sv =====
module ompf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ompf_pkg::t_in i_item,
    input  logic          i_pop,
    output logic          o_busy,
    output ompf_pkg::t_cmd o_cmd
);
    import ompf_pkg::*;

    t_in        r_mem [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_busy = (r_cnt == 2'(QDEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_cnt != 2'd0);

    always_comb begin
        o_cmd.valid = (r_cnt != 2'd0);
        o_cmd.item  = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/ompf_back.sv =====
module ompf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ompf_pkg::t_cfg i_cfg,
    input  logic           i_cfg_wr,
    input  ompf_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_strobe,
    output ompf_pkg::t_out o_out
);
    import ompf_pkg::*;

    t_state r_state, n_state;

    // frame store and bucket store
    logic [23:0] r_frame [MAX_WIDTH*MAX_HEIGHT];
    t_bin        r_bins  [MAX_BINS];
    logic [23:0] r_pix;
    t_bin        r_bq;

    logic [POS_W-1:0] r_pos, r_lpos, r_rem;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_resync;
    logic             r_strobe;
    t_out             r_out;

    logic [8:0]       r_k;
    logic             r_fv;
    t_bin             r_best;
    logic [ROW_W-1:0] r_r;
    logic [COL_W-1:0] r_c, r_cs;
    logic [DIM_W-1:0] r_r1, r_c1;
    logic [POS_W-1:0] r_base;
    logic [7:0]       r_gray;
    logic [BIN_W-1:0] r_bin;
    logic [SUM_W-1:0] r_dq   [3];
    logic [CNT_W-1:0] r_drem [3];
    logic [4:0]       r_it;

    logic [TOT_W-1:0] total;
    logic [POS_W-1:0] lp_eff, lp_next, pos_eff;
    logic [TOT_W-1:0] lp_inc, pos_inc;
    logic             pos_oor, pos_wrap;
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    logic [DIM_W-1:0] r1s, c1s, r1, c1;
    logic [TOT_W-1:0] base0;
    logic [SUM_W-1:0] gsum;
    logic [15:0]      gx;
    logic [16:0]      gy;
    logic [BIN_W-1:0] bin_c;
    logic             c_more, r_more, k_ok, last_it;
    logic [SUM_W-1:0] n_dq   [3];
    logic [CNT_W-1:0] n_drem [3];
    logic [CNT_W:0]   dt     [3];
    logic             dge    [3];

    logic             fw_en, fr_en, bw_en, br_en;
    logic [POS_W-1:0] fr_addr;
    logic [BIN_W-1:0] bw_addr, br_addr;
    t_bin             bw_data;

    assign total   = TOT_W'(i_cfg.width * i_cfg.height);
    assign lp_eff  = ({1'b0, r_lpos} >= total) ? '0 : r_lpos;
    assign lp_inc  = {1'b0, lp_eff} + TOT_W'(1);
    assign lp_next = (lp_inc >= total) ? '0 : lp_inc[POS_W-1:0];
    assign pos_oor = ({1'b0, r_pos} >= total);
    assign pos_eff = pos_oor ? '0 : r_pos;
    assign pos_inc = {1'b0, r_pos} + TOT_W'(1);
    assign pos_wrap = (pos_inc >= total);

    // clipped window bounds, upper bounds exclusive
    assign r0  = (r_row > ROW_W'(i_cfg.radius)) ? r_row - ROW_W'(i_cfg.radius) : '0;
    assign c0  = (r_col > COL_W'(i_cfg.radius)) ? r_col - COL_W'(i_cfg.radius) : '0;
    assign r1s = {1'b0, r_row} + DIM_W'(i_cfg.radius) + DIM_W'(1);
    assign c1s = {1'b0, r_col} + DIM_W'(i_cfg.radius) + DIM_W'(1);
    assign r1  = (r1s > i_cfg.height) ? i_cfg.height : r1s;
    assign c1  = (c1s > i_cfg.width) ? i_cfg.width : c1s;
    assign base0 = TOT_W'(r0 * i_cfg.width);

    assign gsum = SUM_W'(r_pix[7:0]) * SUM_W'(117) + SUM_W'(r_pix[15:8]) * SUM_W'(601)
                + SUM_W'(r_pix[23:16]) * SUM_W'(306);
    // floor(x/255) for x = top*gray, at most 255*255
    assign gx    = 16'(i_cfg.top) * 16'(r_gray);
    assign gy    = 17'(gx) + 17'(gx[15:8]) + 17'd1;
    assign bin_c = gy[15:8];

    assign c_more  = ({1'b0, r_c} + DIM_W'(1)) < r_c1;
    assign r_more  = ({1'b0, r_r} + DIM_W'(1)) < r_r1;
    assign k_ok    = (r_k <= {1'b0, i_cfg.top});
    assign last_it = (r_it == 5'(SUM_W-1));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dt[i]     = {r_drem[i], r_dq[i][SUM_W-1]};
            dge[i]    = (dt[i] >= {1'b0, r_best.cnt});
            n_drem[i] = dge[i] ? CNT_W'(dt[i] - {1'b0, r_best.cnt}) : dt[i][CNT_W-1:0];
            n_dq[i]   = {r_dq[i][SUM_W-2:0], dge[i]};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.item.func == FUNC_EMIT) begin
                    n_state = (!pos_oor && r_resync) ? S_SYNC : S_CLEAR;
                end
            end
            S_SYNC:     if (r_rem < POS_W'(i_cfg.width)) n_state = S_CLEAR;
            S_CLEAR:    if (r_k[7:0] == 8'hFF) n_state = S_PIX_RD;
            S_PIX_RD:   n_state = S_PIX_GRAY;
            S_PIX_GRAY: n_state = S_PIX_BIN;
            S_PIX_BIN:  n_state = S_PIX_ACC;
            S_PIX_ACC:  n_state = (c_more || r_more) ? S_PIX_RD : S_FIND;
            S_FIND:     if (!k_ok && !r_fv) n_state = S_DIV;
            S_DIV:      if (last_it) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        fw_en   = 1'b0;
        fr_en   = 1'b0;
        bw_en   = 1'b0;
        br_en   = 1'b0;
        fr_addr = r_base + POS_W'(r_c);
        bw_addr = r_bin;
        br_addr = bin_c;
        bw_data.cnt = r_bq.cnt + CNT_W'(1);
        bw_data.sb  = r_bq.sb + SUM_W'(r_pix[7:0]);
        bw_data.sg  = r_bq.sg + SUM_W'(r_pix[15:8]);
        bw_data.sr  = r_bq.sr + SUM_W'(r_pix[23:16]);
        case (r_state)
            S_IDLE: begin
                o_pop = i_cmd.valid;
                fw_en = i_cmd.valid && (i_cmd.item.func == FUNC_LOAD);
            end
            S_CLEAR: begin
                bw_en   = 1'b1;
                bw_addr = r_k[7:0];
                bw_data = '0;
            end
            S_PIX_RD:  fr_en = 1'b1;
            S_PIX_BIN: br_en = 1'b1;
            S_PIX_ACC: bw_en = 1'b1;
            S_FIND: begin
                br_en   = k_ok;
                br_addr = r_k[7:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fw_en) begin
            r_frame[lp_eff] <= {i_cmd.item.in_red, i_cmd.item.in_green, i_cmd.item.in_blue};
        end
        if (fr_en) begin
            r_pix <= r_frame[fr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bw_en) begin
            r_bins[bw_addr] <= bw_data;
        end
        if (br_en) begin
            r_bq <= r_bins[br_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_lpos   <= '0;
            r_rem    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_resync <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_DIV) && last_it;
            case (r_state)
                S_IDLE: begin
                    if (fw_en) begin
                        r_lpos <= lp_next;
                    end
                    if (n_state == S_SYNC) begin
                        r_resync <= 1'b0;
                        r_rem    <= r_pos;
                        r_row    <= '0;
                    end else if (n_state == S_CLEAR && pos_oor) begin
                        r_resync <= 1'b0;
                        r_pos    <= pos_eff;
                        r_row    <= '0;
                        r_col    <= '0;
                    end
                end
                S_SYNC: begin
                    if (r_rem >= POS_W'(i_cfg.width)) begin
                        r_rem <= r_rem - POS_W'(i_cfg.width);
                        r_row <= r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_rem[COL_W-1:0];
                    end
                end
                S_DIV: begin
                    if (last_it) begin
                        if (pos_wrap) begin
                            r_pos <= '0;
                            r_row <= '0;
                            r_col <= '0;
                        end else begin
                            r_pos <= pos_inc[POS_W-1:0];
                            if (({1'b0, r_col} + DIM_W'(1)) == i_cfg.width) begin
                                r_col <= '0;
                                r_row <= r_row + ROW_W'(1);
                            end else begin
                                r_col <= r_col + COL_W'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (i_cfg_wr) begin
                r_resync <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE, S_SYNC: r_k <= '0;
            S_CLEAR: begin
                r_k    <= r_k + 9'd1;
                r_r    <= r0;
                r_c    <= c0;
                r_cs   <= c0;
                r_r1   <= r1;
                r_c1   <= c1;
                r_base <= base0[POS_W-1:0];
            end
            S_PIX_GRAY: r_gray <= gsum[SUM_W-1:10];
            S_PIX_BIN:  r_bin  <= bin_c;
            S_PIX_ACC: begin
                if (c_more) begin
                    r_c <= r_c + COL_W'(1);
                end else begin
                    r_c    <= r_cs;
                    r_r    <= r_r + ROW_W'(1);
                    r_base <= r_base + POS_W'(i_cfg.width);
                end
                r_k    <= '0;
                r_fv   <= 1'b0;
                r_best <= '0;
            end
            S_FIND: begin
                if (k_ok) begin
                    r_k <= r_k + 9'd1;
                end
                r_fv <= k_ok;
                if (r_fv && r_bq.cnt > r_best.cnt) begin
                    r_best <= r_bq;
                end
                r_dq[0] <= r_best.sb;
                r_dq[1] <= r_best.sg;
                r_dq[2] <= r_best.sr;
                for (int i = 0; i < 3; i++) begin
                    r_drem[i] <= '0;
                end
                r_it <= '0;
            end
            S_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_dq[i]   <= n_dq[i];
                    r_drem[i] <= n_drem[i];
                end
                r_it <= r_it + 5'd1;
                if (last_it) begin
                    if (r_best.cnt == '0) begin
                        r_out.out_blue  <= '0;
                        r_out.out_green <= '0;
                        r_out.out_red   <= '0;
                    end else begin
                        r_out.out_blue  <= n_dq[0][7:0];
                        r_out.out_green <= n_dq[1][7:0];
                        r_out.out_red   <= n_dq[2][7:0];
                    end
                    r_out.last_pixel <= pos_wrap;
                end
            end
            default: ;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

// ===== rtl/oil_paint_window_mode_filter.sv =====
// load beat: taken into a two-entry queue, written to the frame store on the edge it leaves it
// emit beat: after accept it runs the bucket clear sweep, then a read-modify-write of the bucket store
//   for each window pixel, then the bucket search and the divide, and then raises the strobe
// after a register write the first emit finds row and column by subtracting the width from the raster position
// one emit in flight at a time; result shows for one cycle on o_strobe, receiver cannot stall
// synchronous active-low reset clears positions and queue, sets registers to defaults; frame store undefined
module oil_paint_window_mode_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ompf_pkg::t_in                  i_in,
    output logic                           o_strobe,
    output ompf_pkg::t_out                 o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ompf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ompf_pkg::*;

    // configuration registers as written
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [RAD_W-1:0] r_radius;
    logic [BIN_W-1:0] r_top;

    logic   cfg_wr;
    t_reg   widx;
    t_reg   ridx;
    t_cfg   cfg;
    t_cmd   cmd;
    logic   pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign widx   = t_reg'(paddr[3:2]);
    assign ridx   = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(64);
            r_height <= DIM_W'(64);
            r_radius <= RAD_W'(2);
            r_top    <= BIN_W'(15);
        end else if (cfg_wr) begin
            case (widx)
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                REG_TOP:    r_top    <= pwdata[BIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_RADIUS: prdata = 32'(r_radius);
            REG_TOP:    prdata = 32'(r_top);
            default:    prdata = '0;
        endcase
    end

    // frame sizes saturate to 1..64
    always_comb begin
        if (r_width == '0) begin
            cfg.width = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            cfg.width = DIM_W'(MAX_WIDTH);
        end else begin
            cfg.width = r_width;
        end
        if (r_height == '0) begin
            cfg.height = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            cfg.height = DIM_W'(MAX_HEIGHT);
        end else begin
            cfg.height = r_height;
        end
        cfg.radius = r_radius;
        cfg.top    = r_top;
    end

    // front: accepts beats into the queue
    ompf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_in),
        .i_pop   (pop),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // back: frame store writes and window filtering
    ompf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_cfg_wr (cfg_wr),
        .i_cmd    (cmd),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule

// ===== rtl/ompf_checker.sv =====
module ompf_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         o_strobe,
    input  ompf_pkg::t_out               o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ompf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready
);
    import ompf_pkg::*;

    // a strobe comes from the last divide step and the next emit starts from idle, so results never come back to back
    a_no_double_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    // the queue only fills by taking a beat
    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted beat");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    // width register reads back what was written
    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[3:2] == 2'd0)
        |=> (paddr != $past(paddr) || prdata[6:0] == $past(pwdata[6:0])))
        else $error("width register read back mismatch");

    // a result with last_pixel set is not directly followed by another result
    a_last_bit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last_pixel) |=> !o_strobe)
        else $error("result right after last pixel");

endmodule

bind oil_paint_window_mode_filter ompf_checker u_ompf_checker (.*);
